// ===== src/zrbe_pkg.sv =====
package zrbe_pkg;

  localparam int RunBits    = 16;
  localparam int NdigBits   = $clog2(RunBits + 1);
  localparam int QueueDepth = 4;
  localparam int QPtrBits   = $clog2(QueueDepth);

  localparam logic [RunBits-1:0] RunMax      = {RunBits{1'b1}};
  localparam logic [7:0]         ZeroSymbolReset = 8'd48;

  typedef enum logic [1:0] {
    KIND_LIT  = 2'd0,
    KIND_RUNA = 2'd1,
    KIND_RUNB = 2'd2
  } kind_t;

  typedef struct packed {
    logic [RunBits-1:0]  bits;
    logic [NdigBits-1:0] ndig;
    logic                has_lit;
    logic [7:0]          lit;
  } job_t;

  function automatic logic [NdigBits-1:0] msb_index(input logic [RunBits:0] v);
    logic [NdigBits-1:0] idx;
    idx = '0;
    for (int i = 0; i <= RunBits; i++) begin
      if (v[i]) begin
        idx = NdigBits'(i);
      end
    end
    return idx;
  endfunction

endpackage

// ===== src/zrbe_queue.sv =====
module zrbe_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  zrbe_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output zrbe_pkg::job_t head,
  output logic          empty
);
  import zrbe_pkg::*;

  job_t                entries [QueueDepth];
  logic [QPtrBits-1:0] wr_ptr;
  logic [QPtrBits-1:0] rd_ptr;
  logic [QPtrBits:0]   count;
  logic                do_push;
  logic                do_pop;

  assign full    = (count == (QPtrBits+1)'(QueueDepth));
  assign empty   = (count == '0);
  assign head    = entries[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_job;
    end
  end

endmodule

// ===== src/zrbe_front.sv =====
module zrbe_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [7:0]    symbol,
  input  logic          end_of_stream,
  input  logic          cfg_wr_en,
  input  logic [7:0]    cfg_wr_data,
  input  logic          q_full,
  output logic          push,
  output zrbe_pkg::job_t push_job
);
  import zrbe_pkg::*;

  logic [7:0]          zero_symbol;
  logic [RunBits-1:0]  run_length;
  logic [RunBits-1:0]  run_length_next;
  logic                accept;
  logic                is_zero;
  logic [RunBits-1:0]  len_inc;
  logic [RunBits-1:0]  run_cnt;
  logic                flush_run;
  logic [RunBits:0]    code;
  logic [NdigBits-1:0] top;
  logic [RunBits:0]    aligned;

  assign in_ready = !q_full;
  assign accept   = in_valid && !q_full;

  always_comb begin
    is_zero   = (symbol == zero_symbol);
    len_inc   = (run_length < RunMax) ? run_length + 1'b1 : run_length;
    run_cnt   = is_zero ? len_inc : run_length;
    flush_run = is_zero ? ((len_inc == RunMax) || end_of_stream) : (run_length != '0);
    code      = {1'b0, run_cnt} + 1'b1;
    top       = msb_index(code);
    aligned   = code << (NdigBits'(RunBits) - top);

    push             = accept && (!is_zero || flush_run);
    push_job.bits    = flush_run ? aligned[RunBits-1:0] : '0;
    push_job.ndig    = flush_run ? top : '0;
    push_job.has_lit = !is_zero;
    push_job.lit     = symbol;

    run_length_next = (is_zero && !flush_run) ? len_inc : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      zero_symbol <= ZeroSymbolReset;
      run_length  <= '0;
    end else begin
      if (cfg_wr_en) begin
        zero_symbol <= cfg_wr_data;
      end
      if (accept) begin
        run_length <= run_length_next;
      end
    end
  end

endmodule

// ===== src/zrbe_back.sv =====
module zrbe_back (
  input  logic          clk,
  input  logic          rst,
  input  zrbe_pkg::job_t head,
  input  logic          q_empty,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [1:0]    kind,
  output logic [7:0]    literal,
  output logic          last
);
  import zrbe_pkg::*;

  job_t  cur;
  logic  job_valid;
  logic  emit_ok;
  logic  is_digit;
  kind_t res_kind;
  logic  res_last;
  logic  load;

  always_comb begin
    emit_ok  = job_valid && (!out_valid || out_ready);
    is_digit = (cur.ndig != '0);
    if (is_digit) begin
      res_kind = cur.bits[RunBits-1] ? KIND_RUNB : KIND_RUNA;
      res_last = (cur.ndig == NdigBits'(1)) && !cur.has_lit;
    end else begin
      res_kind = KIND_LIT;
      res_last = 1'b1;
    end
    load = (!job_valid || (emit_ok && res_last)) && !q_empty;
    pop  = load;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        job_valid <= 1'b1;
      end else if (emit_ok && res_last) begin
        job_valid <= 1'b0;
      end
      if (emit_ok) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur <= head;
    end else if (emit_ok && is_digit) begin
      cur.bits <= cur.bits << 1;
      cur.ndig <= cur.ndig - 1'b1;
    end
    if (emit_ok) begin
      kind    <= res_kind;
      literal <= is_digit ? 8'd0 : cur.lit;
      last    <= res_last;
    end
  end

endmodule

// ===== src/zero_run_bijective_encoder.sv =====
// An accepted request passes the job queue, the back-end job register and the output
// register in order. Throughput: one request per cycle while the queue is not full; one
// result per cycle while not stalled, set by the back-end digit generator, so a run
// flush of N digits yields N results while a four-entry job queue keeps input flowing.
// Reset (rst, synchronous, active high): clears the run counter, queue and output,
// and sets the zero symbol to 48.
module zero_run_bijective_encoder (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] symbol
  input  logic       s_axis_tlast,
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] literal
  output logic [1:0] m_axis_tuser,   // [1:0] kind
  output logic       m_axis_tlast,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data
);
  import zrbe_pkg::*;

  logic q_full;
  logic q_empty;
  logic push;
  logic pop;
  job_t push_job;
  job_t head;

  zrbe_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (s_axis_tvalid),
    .in_ready      (s_axis_tready),
    .symbol        (s_axis_tdata),
    .end_of_stream (s_axis_tlast),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .q_full        (q_full),
    .push          (push),
    .push_job      (push_job)
  );

  zrbe_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (pop),
    .head     (head),
    .empty    (q_empty)
  );

  zrbe_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .q_empty   (q_empty),
    .pop       (pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .kind      (m_axis_tuser),
    .literal   (m_axis_tdata),
    .last      (m_axis_tlast)
  );

endmodule
